// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
package ple_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 3;

   localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE   = 3'd0;
   localparam logic [STAT_W-1:0] ST_POSERR = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STAT_W-1:0] ST_ELEM   = 3'd4;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             ins;      // shift toward the tail, front takes the new value
      logic             del;      // cells at or behind del_idx take their successor
      logic             rot;      // rotate one place toward the front
      logic [IDX_W-1:0] del_idx;
      logic [IDX_W-1:0] tail_idx; // last occupied cell, takes the front on rotate
   } cell_ctrl_type;

endpackage

// ===== rtl/ple_if.sv =====
`timescale 1ns / 1ps
interface ple_req_if;
   import ple_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, kind, value, position, input ready);
   modport sink (input valid, kind, value, position, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] element;
   logic                     last;

   modport source (output valid, status, element, last, input ready);
   modport sink (input valid, status, element, last, output ready);
endinterface

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps
module ple_cell
   import ple_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]         idx,
   input  logic signed [DATA_W-1:0] prev_data,
   input  logic signed [DATA_W-1:0] next_data,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctrl.ins) begin
         data_in = prev_data;
      end else if (ctrl.del) begin
         if (idx >= ctrl.del_idx) data_in = next_data;
      end else if (ctrl.rot) begin
         data_in = (idx == ctrl.tail_idx) ? head_data : next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/positional_list_engine_core.sv =====
`timescale 1ns / 1ps
// Bounded ordered list held in a chain of CAPACITY cells, cell 0 being the front.
// Insert and delete are taken one item per cycle while rsp is ready: on a done
// item the cells move one place in the same cycle (on delete only those at or
// behind the position) and the single reply goes to the output register. A
// display item with N stored elements produces N replies, one per cycle while
// rsp is ready, by rotating the occupied cells toward the front and reading
// cell 0; after N rotations the list is back in order. No new item is taken
// during that readout, and an empty list gets a single reply.
module positional_list_engine_core
   import ple_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ple_req_if.sink    req_ch,
   ple_rsp_if.source  rsp_ch
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_STREAM = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         rd_ff, rd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic                     last_ff, last_in;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   logic req_fire;
   logic slot_free;
   logic is_full;
   logic bad_pos;

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign bad_pos      = (req_ch.position == '0) || (req_ch.position > POS_W'(count_ff));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      ctrl.ins      = 1'b0;
      ctrl.del      = 1'b0;
      ctrl.rot      = 1'b0;
      ctrl.del_idx  = IDX_W'(req_ch.position - POS_W'(1));
      ctrl.tail_idx = IDX_W'(count_ff - CNT_W'(1));

      if (req_fire) begin
         element_in = '0;
         last_in    = 1'b1;
         unique case (req_ch.kind)
            KIND_INSERT: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  ctrl.ins  = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            KIND_DELETE: begin
               rsp_valid_in = 1'b1;
               if (bad_pos) begin
                  status_in = ST_POSERR;
               end else begin
                  status_in = ST_DONE;
                  ctrl.del  = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            default: begin
               // display, also taken for the unused kind code
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_EMPTY;
               end else begin
                  state_in = ST_STREAM;
                  rd_in    = '0;
               end
            end
         endcase
      end else if (state_ff == ST_STREAM && slot_free) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_ELEM;
         element_in   = cell_data[0];
         last_in      = (rd_ff == ctrl.tail_idx);
         ctrl.rot     = 1'b1;
         rd_in        = rd_ff + IDX_W'(1);
         if (rd_ff == ctrl.tail_idx) state_in = ST_IDLE;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [DATA_W-1:0] prev_w;
         logic signed [DATA_W-1:0] next_w;
         if (gi == 0) begin : g_front
            assign prev_w = req_ch.value;
         end else begin : g_mid_prev
            assign prev_w = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_back
            assign next_w = cell_data[0];
         end else begin : g_mid_next
            assign next_w = cell_data[gi+1];
         end
         ple_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .idx       (IDX_W'(gi)),
            .prev_data (prev_w),
            .next_data (next_w),
            .head_data (cell_data[0]),
            .data      (cell_data[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.element = element_ff;
   assign rsp_ch.last    = last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_no_take_in_stream : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> !req_ch.ready)
      else $error("item taken during readout");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind == KIND_INSERT && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_non_elem_reply : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_ELEM |-> element_ff == '0 && last_ff)
      else $error("bad single reply fields");

endmodule
